// ----- rtl/btbp_pkg.sv -----
// Shared types and constants of the two-level branch predictor.
package btbp_pkg;

    localparam int BTB_ENTRIES = 32;
    localparam int IDX_W       = 5;
    localparam int HIST_MAX    = 8;
    localparam int TAG_MAX     = 25;
    localparam int CTR_SLOTS   = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_HIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_CTR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MODE   = 3'd6;

    localparam logic [1:0] SHARE_XOR_LOW  = 2'd1;
    localparam logic [1:0] SHARE_XOR_HIGH = 2'd2;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] pc;
        logic [31:0] actual_target;
        logic        actual_taken;
        logic [31:0] earlier_prediction;
    } item_t;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] next_pc;
        logic        flushed;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } result_t;

    typedef struct packed {
        logic [TAG_MAX-1:0]  tag;
        logic [31:0]         target;
        logic [HIST_MAX-1:0] hist;
    } entry_t;

    typedef struct packed {
        logic             rd;
        logic             we;
        logic [IDX_W-1:0] slot;
        entry_t           data;
    } ent_cmd_t;

    typedef struct packed {
        logic                rd;
        logic                ent_we;
        logic                glb_we;
        logic                glb_clear;
        logic [IDX_W-1:0]    slot;
        logic [HIST_MAX-1:0] ci;
        logic [1:0]          wdata;
    } ctr_cmd_t;

endpackage

// ----- rtl/btb_two_level_branch_predictor.sv -----
// Top level: BTB with two-level direction prediction, sequencer and counters.
// Predict beat and update on a tag hit: lookup in S_LOOK, counter access in S_CTR, then the registered result strobe.
// Update that installs a new tag adds S_FILL, a walk that rewrites all 256 slots of the
// entry's counter table one slot a cycle through its write port, and then S_RDC.
// One item at a time; busy is high from the accepting edge until the result.
// Reset clears valid bits, global history and counts and sets the configuration to defaults; no clearing pass.
module btb_two_level_branch_predictor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  btbp_pkg::item_t                       item,
    output logic                                  done,
    output btbp_pkg::result_t                     result,
    input  logic                                  cfg_we,
    input  logic [btbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [btbp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_FILL = 5'b00100,
        S_RDC  = 5'b01000,
        S_CTR  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0] idx_bits_reg;
    logic [3:0] hist_bits_reg;
    logic [4:0] tag_bits_reg;
    logic [1:0] init_ctr_reg;
    logic       sh_hist_reg;
    logic       sh_ctr_reg;
    logic [1:0] share_mode_reg;

    logic [btbp_pkg::BTB_ENTRIES-1:0] valid_reg;
    logic [btbp_pkg::HIST_MAX-1:0]    ghist_reg;
    logic [31:0]                      branches_reg;
    logic [31:0]                      flushes_reg;

    btbp_pkg::item_t                  it_reg;
    logic [btbp_pkg::IDX_W-1:0]       slot_reg;
    logic [btbp_pkg::TAG_MAX-1:0]     tag_reg;
    logic                             hit_reg;
    logic [31:0]                      target_reg;
    logic [btbp_pkg::HIST_MAX-1:0]    ehist_reg;
    logic [btbp_pkg::HIST_MAX-1:0]    ci_reg;
    logic [btbp_pkg::HIST_MAX-1:0]    sweep_reg;

    logic                             done_reg;
    btbp_pkg::result_t                result_reg;

    btbp_pkg::ent_cmd_t ent_cmd;
    btbp_pkg::entry_t   ent_q;
    btbp_pkg::ctr_cmd_t ctr_cmd;
    logic [1:0]         ent_ctr_q;
    logic [1:0]         glb_ctr_q;

    logic [2:0]                       ib;
    logic [3:0]                       hb;
    logic [4:0]                       tb;
    logic [btbp_pkg::IDX_W-1:0]       slot_mask;
    logic [btbp_pkg::HIST_MAX-1:0]    hmask;
    logic [btbp_pkg::TAG_MAX-1:0]     tmask;
    logic [31:0]                      pc_shift;
    logic [btbp_pkg::IDX_W-1:0]       slot_in;
    logic [btbp_pkg::TAG_MAX-1:0]     tag_in;
    logic                             hit_now;
    logic                             install;
    logic [btbp_pkg::HIST_MAX-1:0]    ehist_now;
    logic [btbp_pkg::HIST_MAX-1:0]    h_sel;
    logic [btbp_pkg::HIST_MAX-1:0]    ci_now;
    logic [1:0]                       ctr_cur;
    logic [1:0]                       ctr_new;
    logic [31:0]                      pc4;
    logic                             fl;
    logic                             ptaken;

    btbp_entry_store u_entry (
        .clk (clk),
        .cmd (ent_cmd),
        .q   (ent_q)
    );

    btbp_ctr_store u_ctr (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ctr_cmd),
        .glb_init (init_ctr_reg),
        .ent_q    (ent_ctr_q),
        .glb_q    (glb_ctr_q)
    );

    always_comb
    begin
        ib        = (idx_bits_reg > 3'd5) ? 3'd5 : idx_bits_reg;
        hb        = (hist_bits_reg > 4'd8) ? 4'd8 : hist_bits_reg;
        tb        = (tag_bits_reg > 5'd25) ? 5'd25 : tag_bits_reg;
        slot_mask = 5'((6'd1 << ib) - 6'd1);
        hmask     = 8'((9'd1 << hb) - 9'd1);
        tmask     = 25'((26'd1 << tb) - 26'd1);
        pc_shift  = item.pc >> (6'd2 + 6'(ib));
        slot_in   = item.pc[6:2] & slot_mask;
        tag_in    = pc_shift[24:0] & tmask;

        hit_now   = valid_reg[slot_reg] && (ent_q.tag == tag_reg);
        install   = (it_reg.mode == btbp_pkg::MODE_UPDATE) && !hit_now;
        ehist_now = install ? '0 : ent_q.hist;
        h_sel     = (sh_hist_reg ? ghist_reg : ehist_now) & hmask;
        ci_now    = h_sel;
        if (sh_ctr_reg)
        begin
            case (share_mode_reg)
                btbp_pkg::SHARE_XOR_LOW:  ci_now = h_sel ^ (it_reg.pc[9:2] & hmask);
                btbp_pkg::SHARE_XOR_HIGH: ci_now = h_sel ^ (it_reg.pc[23:16] & hmask);
                default:                  ci_now = h_sel;
            endcase
        end

        ctr_cur = sh_ctr_reg ? glb_ctr_q : ent_ctr_q;
        pc4     = it_reg.pc + 32'd4;
        if (it_reg.actual_taken)
        begin
            ctr_new = (ctr_cur == 2'd3) ? ctr_cur : ctr_cur + 2'd1;
            fl      = it_reg.actual_target != it_reg.earlier_prediction;
        end
        else
        begin
            ctr_new = (ctr_cur == 2'd0) ? ctr_cur : ctr_cur - 2'd1;
            fl      = it_reg.earlier_prediction != pc4;
        end
        ptaken = hit_reg && ctr_cur[1];
    end

    always_comb
    begin
        state_next = state_reg;
        ent_cmd    = '0;
        ctr_cmd    = '0;
        ctr_cmd.glb_clear = cfg_we && (cfg_index == btbp_pkg::CFG_INIT_CTR);
        unique case (state_reg)
            S_IDLE:
            begin
                ent_cmd.slot = slot_in;
                if (start)
                begin
                    ent_cmd.rd = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ctr_cmd.slot = slot_reg;
                ctr_cmd.ci   = ci_now;
                if (install)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    ctr_cmd.rd = 1'b1;
                    state_next = S_CTR;
                end
            end
            S_FILL:
            begin
                ctr_cmd.ent_we = 1'b1;
                ctr_cmd.slot   = slot_reg;
                ctr_cmd.ci     = sweep_reg;
                ctr_cmd.wdata  = init_ctr_reg;
                if (sweep_reg == '1)
                begin
                    state_next = S_RDC;
                end
            end
            S_RDC:
            begin
                ctr_cmd.rd   = 1'b1;
                ctr_cmd.slot = slot_reg;
                ctr_cmd.ci   = ci_reg;
                state_next   = S_CTR;
            end
            S_CTR:
            begin
                ctr_cmd.slot  = slot_reg;
                ctr_cmd.ci    = ci_reg;
                ctr_cmd.wdata = ctr_new;
                ent_cmd.slot  = slot_reg;
                ent_cmd.data.tag    = tag_reg;
                ent_cmd.data.target = it_reg.actual_target;
                ent_cmd.data.hist   = sh_hist_reg ? ehist_reg
                                                  : {ehist_reg[6:0], it_reg.actual_taken};
                if (it_reg.mode == btbp_pkg::MODE_UPDATE)
                begin
                    ent_cmd.we     = 1'b1;
                    ctr_cmd.ent_we = !sh_ctr_reg;
                    ctr_cmd.glb_we = sh_ctr_reg;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_bits_reg   <= 3'd5;
            hist_bits_reg  <= 4'd8;
            tag_bits_reg   <= 5'd25;
            init_ctr_reg   <= 2'd1;
            sh_hist_reg    <= 1'b0;
            sh_ctr_reg     <= 1'b0;
            share_mode_reg <= 2'd0;
            valid_reg      <= '0;
            ghist_reg      <= '0;
            branches_reg   <= '0;
            flushes_reg    <= '0;
            done_reg       <= 1'b0;
            sweep_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_CTR);
            if (cfg_we)
            begin
                case (cfg_index)
                    btbp_pkg::CFG_INDEX_BITS:   idx_bits_reg   <= cfg_data[2:0];
                    btbp_pkg::CFG_HISTORY_BITS: hist_bits_reg  <= cfg_data[3:0];
                    btbp_pkg::CFG_TAG_BITS:     tag_bits_reg   <= cfg_data[4:0];
                    btbp_pkg::CFG_INIT_CTR:     init_ctr_reg   <= cfg_data[1:0];
                    btbp_pkg::CFG_SHARED_HIST:  sh_hist_reg    <= cfg_data[0];
                    btbp_pkg::CFG_SHARED_CTR:   sh_ctr_reg     <= cfg_data[0];
                    btbp_pkg::CFG_SHARE_MODE:   share_mode_reg <= cfg_data[1:0];
                    default:                    ;
                endcase
            end
            if (state_reg == S_FILL)
            begin
                sweep_reg <= sweep_reg + 8'd1;
            end
            else
            begin
                sweep_reg <= '0;
            end
            if ((state_reg == S_CTR) && (it_reg.mode == btbp_pkg::MODE_UPDATE))
            begin
                valid_reg[slot_reg] <= 1'b1;
                branches_reg        <= branches_reg + 32'd1;
                flushes_reg         <= flushes_reg + {31'd0, fl};
                if (sh_hist_reg)
                begin
                    ghist_reg <= {ghist_reg[6:0], it_reg.actual_taken};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            it_reg   <= item;
            slot_reg <= slot_in;
            tag_reg  <= tag_in;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg    <= hit_now;
            target_reg <= ent_q.target;
            ehist_reg  <= ehist_now;
            ci_reg     <= ci_now;
        end
        if (state_reg == S_CTR)
        begin
            if (it_reg.mode == btbp_pkg::MODE_UPDATE)
            begin
                result_reg.predict_taken <= 1'b0;
                result_reg.next_pc       <= '0;
                result_reg.flushed       <= fl;
                result_reg.branch_count  <= branches_reg + 32'd1;
                result_reg.flush_count   <= flushes_reg + {31'd0, fl};
            end
            else
            begin
                result_reg.predict_taken <= ptaken;
                result_reg.next_pc       <= ptaken ? target_reg : pc4;
                result_reg.flushed       <= 1'b0;
                result_reg.branch_count  <= branches_reg;
                result_reg.flush_count   <= flushes_reg;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/btbp_entry_store.sv -----
// Tag, target and local history memory of the branch target buffer.
module btbp_entry_store (
    input  logic                clk,
    input  btbp_pkg::ent_cmd_t  cmd,
    output btbp_pkg::entry_t    q
);

    btbp_pkg::entry_t mem [btbp_pkg::BTB_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.slot] <= cmd.data;
        end
        if (cmd.rd)
        begin
            q <= mem[cmd.slot];
        end
    end

endmodule

// ----- rtl/btbp_ctr_store.sv -----
// Per-entry and global saturating counter memories.
module btbp_ctr_store (
    input  logic               clk,
    input  logic               rst_n,
    input  btbp_pkg::ctr_cmd_t cmd,
    input  logic [1:0]         glb_init,
    output logic [1:0]         ent_q,
    output logic [1:0]         glb_q
);

    logic [1:0] ent_mem [btbp_pkg::BTB_ENTRIES * btbp_pkg::CTR_SLOTS];
    logic [1:0] glb_mem [btbp_pkg::CTR_SLOTS];
    logic [btbp_pkg::CTR_SLOTS-1:0] glb_valid_reg;
    logic [1:0] glb_raw_reg;
    logic       glb_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ent_we)
        begin
            ent_mem[{cmd.slot, cmd.ci}] <= cmd.wdata;
        end
        if (cmd.glb_we)
        begin
            glb_mem[cmd.ci] <= cmd.wdata;
        end
        if (cmd.rd)
        begin
            ent_q       <= ent_mem[{cmd.slot, cmd.ci}];
            glb_raw_reg <= glb_mem[cmd.ci];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glb_valid_reg <= '0;
            glb_hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.glb_clear)
            begin
                glb_valid_reg <= '0;
            end
            else if (cmd.glb_we)
            begin
                glb_valid_reg[cmd.ci] <= 1'b1;
            end
            if (cmd.rd)
            begin
                glb_hit_reg <= glb_valid_reg[cmd.ci];
            end
        end
    end

    assign glb_q = glb_hit_reg ? glb_raw_reg : glb_init;

endmodule

// ----- rtl/btbp_checker.sv -----
// Port-level assertions for the branch predictor, bound to the top level.
module btbp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input btbp_pkg::result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats in a row");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.flushed |-> !result.predict_taken)
        else $error("result mixes predict and update fields");

endmodule

bind btb_two_level_branch_predictor btbp_checker u_btbp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
